// File: rtl/nht_pkg.sv
// Shared types, constants and encodings for the held-note tracker.
package nht_pkg;

  // Table geometry and limits
  parameter int KEY_SLOTS = 2048;
  parameter int HELD_MAX  = 64;

  localparam int ADDR_W  = $clog2(KEY_SLOTS);
  localparam int SLOT_W  = 11;               // channel (4 bits) and key (7 bits)
  localparam int CNT_W   = 7;
  localparam int LIMIT_W = 7;
  localparam int ALU_W   = ADDR_W;

  localparam logic [ADDR_W-1:0]  LAST_ADDR    = ADDR_W'(KEY_SLOTS - 1);
  localparam logic [SLOT_W:0]    SLOT_BOUND   = (SLOT_W + 1)'(KEY_SLOTS);
  localparam logic [LIMIT_W-1:0] HELD_MAX_LIM = LIMIT_W'(HELD_MAX);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd64;

  // APB register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_HELD_LIMIT = '0;

  // MIDI encodings
  localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
  localparam logic [3:0] MSG_CONTROLLER = 4'hb;
  localparam logic [7:0] CC_SUSTAIN     = 8'd64;
  localparam logic [7:0] CC_SOSTENUTO   = 8'd66;
  localparam logic [7:0] PEDAL_DOWN_MIN = 8'd64;
  localparam logic [1:0] FULL_EVENT_LEN = 2'd3;

  // Result kinds
  localparam logic RES_STATUS   = 1'b0;
  localparam logic RES_NOTE_OFF = 1'b1;

  typedef enum logic [1:0] {
    OP_EVENT       = 2'd0,
    OP_CLEANUP     = 2'd1,
    OP_VOICE_RESET = 2'd2,
    OP_FULL_RESET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_INC  = 2'd1,
    ACT_DEC  = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_MOD,
    ST_EV_TOT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] byte_count;
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         midi_channel;
    logic [6:0]         key_number;
    logic               last;
    logic [CNT_W-1:0]   held_total;
    logic               rejected;
    logic               sustain_latched;
    logic               voices_started;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } tbl_req_t;

endpackage

// File: rtl/nht_alu.sv
// Shared increment/decrement unit used by the sequencer for table count, total, remaining count and address steps.
module nht_alu (
  input  logic [nht_pkg::ALU_W-1:0] a,
  input  logic                      dec,
  output logic [nht_pkg::ALU_W-1:0] y
);

  // One adder, operand steered by the sequencer
  assign y = dec ? (a - nht_pkg::ALU_W'(1)) : (a + nht_pkg::ALU_W'(1));

endmodule

// File: rtl/nht_table.sv
// Held-count table: one write port, one registered read port.
module nht_table (
  input  logic                      clk,
  input  nht_pkg::tbl_req_t         req,
  output logic [nht_pkg::CNT_W-1:0] rd_data
);

  logic [nht_pkg::CNT_W-1:0] mem [nht_pkg::KEY_SLOTS];
  logic [nht_pkg::CNT_W-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/nht_ctrl.sv
// Sequencer: event read-modify-write, table walk for cleanup, clearing pass, result register.
module nht_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  nht_pkg::item_t              item,
  input  logic [nht_pkg::LIMIT_W-1:0] held_limit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output nht_pkg::result_t            res,
  output nht_pkg::tbl_req_t           tbl_req,
  input  logic [nht_pkg::CNT_W-1:0]   tbl_rd_data
);

  nht_pkg::state_t              state_r, state_nxt;
  logic [nht_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [nht_pkg::CNT_W-1:0]    total_r, total_nxt;
  logic                         sustain_r, sustain_nxt;
  logic                         voices_r, voices_nxt;
  logic                         clr_resp_r, clr_resp_nxt;
  logic                         out_valid_r, out_valid_nxt;
  nht_pkg::result_t             res_r, res_nxt;
  logic                         rej_r, rej_nxt;
  nht_pkg::act_t                act_r, act_nxt;
  logic                         in_range_r, in_range_nxt;
  logic [1:0]                   len_r, len_nxt;
  logic [3:0]                   msg_r, msg_nxt;
  logic [7:0]                   d1_r, d1_nxt;
  logic [7:0]                   d2_r, d2_nxt;
  logic [nht_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [nht_pkg::CNT_W-1:0]    left_r, left_nxt;

  logic [nht_pkg::ALU_W-1:0]    alu_a, alu_y;
  logic                         alu_dec;
  logic [nht_pkg::SLOT_W-1:0]   in_slot, cur_slot;
  logic [nht_pkg::LIMIT_W-1:0]  lim;
  logic                         out_free;
  logic                         full_len, note_on, note_off, pedal;

  nht_alu u_alu (
    .a   (alu_a),
    .dec (alu_dec),
    .y   (alu_y)
  );

  // Slot of the incoming item and of the walk position
  assign in_slot  = {item.status_byte[3:0], item.data_one[6:0]};
  assign cur_slot = nht_pkg::SLOT_W'(addr_r);
  assign lim      = (held_limit > nht_pkg::HELD_MAX_LIM) ? nht_pkg::HELD_MAX_LIM : held_limit;
  assign out_free = !out_valid_r || !out_stall;

  // Event decode on the latched item
  assign full_len = (len_r == nht_pkg::FULL_EVENT_LEN);
  assign note_on  = full_len && (msg_r == nht_pkg::MSG_NOTE_ON) && (d2_r != 8'd0);
  assign note_off = full_len && ((msg_r == nht_pkg::MSG_NOTE_OFF) ||
                    (msg_r == nht_pkg::MSG_NOTE_ON)) && in_range_r &&
                    (tbl_rd_data != '0);
  assign pedal    = full_len && (msg_r == nht_pkg::MSG_CONTROLLER) &&
                    ((d1_r == nht_pkg::CC_SUSTAIN) || (d1_r == nht_pkg::CC_SOSTENUTO)) &&
                    (d2_r >= nht_pkg::PEDAL_DOWN_MIN);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nht_pkg::ST_CLEAR;
      addr_r      <= '0;
      total_r     <= '0;
      sustain_r   <= 1'b0;
      voices_r    <= 1'b0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      act_r       <= nht_pkg::ACT_NONE;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      total_r     <= total_nxt;
      sustain_r   <= sustain_nxt;
      voices_r    <= voices_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    rej_r      <= rej_nxt;
    in_range_r <= in_range_nxt;
    len_r      <= len_nxt;
    msg_r      <= msg_nxt;
    d1_r       <= d1_nxt;
    d2_r       <= d2_nxt;
    rem_r      <= rem_nxt;
    left_r     <= left_nxt;
  end

  // Next state and datapath steering
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    total_nxt     = total_r;
    sustain_nxt   = sustain_r;
    voices_nxt    = voices_r;
    clr_resp_nxt  = clr_resp_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    rej_nxt       = rej_r;
    act_nxt       = act_r;
    in_range_nxt  = in_range_r;
    len_nxt       = len_r;
    msg_nxt       = msg_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    rem_nxt       = rem_r;
    left_nxt      = left_r;

    alu_a         = nht_pkg::ALU_W'(addr_r);
    alu_dec       = 1'b0;

    tbl_req.wr_en   = 1'b0;
    tbl_req.wr_addr = addr_r;
    tbl_req.wr_data = alu_y[nht_pkg::CNT_W-1:0];
    tbl_req.rd_addr = addr_r;

    unique case (state_r)
      // Clearing pass, one slot a cycle
      nht_pkg::ST_CLEAR: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_data = '0;
        if (addr_r == nht_pkg::LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = clr_resp_r ? nht_pkg::ST_RESP : nht_pkg::ST_IDLE;
        end else begin
          addr_nxt = alu_y[nht_pkg::ADDR_W-1:0];
        end
      end

      nht_pkg::ST_IDLE: begin
        tbl_req.rd_addr = in_slot[nht_pkg::ADDR_W-1:0];
        if (in_valid) begin
          rej_nxt = 1'b0;
          unique case (nht_pkg::op_t'(item.operation))
            nht_pkg::OP_EVENT: begin
              addr_nxt     = in_slot[nht_pkg::ADDR_W-1:0];
              in_range_nxt = ({1'b0, in_slot} < nht_pkg::SLOT_BOUND);
              len_nxt      = item.byte_count;
              msg_nxt      = item.status_byte[7:4];
              d1_nxt       = item.data_one;
              d2_nxt       = item.data_two;
              state_nxt    = nht_pkg::ST_EV_MOD;
            end
            nht_pkg::OP_CLEANUP: begin
              if (total_r == '0) begin
                state_nxt = nht_pkg::ST_RESP;
              end else begin
                addr_nxt  = '0;
                left_nxt  = total_r;
                state_nxt = nht_pkg::ST_WALK_RD;
              end
            end
            nht_pkg::OP_VOICE_RESET: begin
              total_nxt    = '0;
              voices_nxt   = 1'b0;
              addr_nxt     = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = nht_pkg::ST_CLEAR;
            end
            nht_pkg::OP_FULL_RESET: begin
              total_nxt    = '0;
              voices_nxt   = 1'b0;
              sustain_nxt  = 1'b0;
              addr_nxt     = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = nht_pkg::ST_CLEAR;
            end
            default: state_nxt = nht_pkg::ST_IDLE;
          endcase
        end
      end

      // Count read back: decide and write the updated count, or latch the pedal
      nht_pkg::ST_EV_MOD: begin
        alu_a   = nht_pkg::ALU_W'(tbl_rd_data);
        act_nxt = nht_pkg::ACT_NONE;
        if (note_on) begin
          if (in_range_r) begin
            if (total_r >= lim) begin
              rej_nxt = 1'b1;
            end else begin
              act_nxt       = nht_pkg::ACT_INC;
              tbl_req.wr_en = 1'b1;
              voices_nxt    = 1'b1;
            end
          end
        end else if (note_off) begin
          act_nxt       = nht_pkg::ACT_DEC;
          alu_dec       = 1'b1;
          tbl_req.wr_en = 1'b1;
        end else if (pedal) begin
          sustain_nxt = 1'b1;
        end
        state_nxt = nht_pkg::ST_EV_TOT;
      end

      // Running total follows the count change
      nht_pkg::ST_EV_TOT: begin
        alu_a   = nht_pkg::ALU_W'(total_r);
        alu_dec = (act_r == nht_pkg::ACT_DEC);
        if (act_r != nht_pkg::ACT_NONE) begin
          total_nxt = alu_y[nht_pkg::CNT_W-1:0];
        end
        state_nxt = nht_pkg::ST_RESP;
      end

      nht_pkg::ST_WALK_RD: begin
        state_nxt = nht_pkg::ST_WALK_CHK;
      end

      nht_pkg::ST_WALK_CHK: begin
        if (tbl_rd_data != '0) begin
          rem_nxt   = tbl_rd_data;
          state_nxt = nht_pkg::ST_EMIT;
        end else begin
          addr_nxt  = alu_y[nht_pkg::ADDR_W-1:0];
          state_nxt = nht_pkg::ST_WALK_RD;
        end
      end

      // One note-off per held instance
      nht_pkg::ST_EMIT: begin
        if (rem_r == nht_pkg::CNT_W'(1)) begin
          alu_a = nht_pkg::ALU_W'(addr_r);
        end else begin
          alu_a   = nht_pkg::ALU_W'(rem_r);
          alu_dec = 1'b1;
        end
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          res_nxt.kind            = nht_pkg::RES_NOTE_OFF;
          res_nxt.midi_channel    = cur_slot[10:7];
          res_nxt.key_number      = cur_slot[6:0];
          res_nxt.last            = (left_r == nht_pkg::CNT_W'(1));
          res_nxt.held_total      = total_r;
          res_nxt.rejected        = 1'b0;
          res_nxt.sustain_latched = sustain_r;
          res_nxt.voices_started  = voices_r;
          left_nxt                = left_r - nht_pkg::CNT_W'(1);
          if (left_r == nht_pkg::CNT_W'(1)) begin
            state_nxt = nht_pkg::ST_IDLE;
          end else if (rem_r == nht_pkg::CNT_W'(1)) begin
            addr_nxt  = alu_y[nht_pkg::ADDR_W-1:0];
            state_nxt = nht_pkg::ST_WALK_RD;
          end else begin
            rem_nxt = alu_y[nht_pkg::CNT_W-1:0];
          end
        end
      end

      // Status result
      nht_pkg::ST_RESP: begin
        clr_resp_nxt = 1'b0;
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          res_nxt.kind            = nht_pkg::RES_STATUS;
          res_nxt.midi_channel    = '0;
          res_nxt.key_number      = '0;
          res_nxt.last            = 1'b1;
          res_nxt.held_total      = total_r;
          res_nxt.rejected        = rej_r;
          res_nxt.sustain_latched = sustain_r;
          res_nxt.voices_started  = voices_r;
          state_nxt               = nht_pkg::ST_IDLE;
        end
      end

      default: state_nxt = nht_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != nht_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// File: rtl/midi_held_note_tracker_unit.sv
// A MIDI event goes through the count read-modify-write, the total update and the status result
// register; no new event is taken until its result is registered. Cleanup walks the count table,
// reading then checking each slot (one read port, registered read), and emits one note-off per held
// instance, waiting on output stalls. Voice and full reset rewrite every slot, one per cycle, then
// give the status result. After rst_n the same clearing pass runs with in_stall high;
// APB writes are taken. held_limit resets to 64 and keeps its value across voice and full reset.
module midi_held_note_tracker_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_operation,
  input  logic [1:0]                     in_byte_count,
  input  logic [7:0]                     in_status_byte,
  input  logic [7:0]                     in_data_one,
  input  logic [7:0]                     in_data_two,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [3:0]                     out_midi_channel,
  output logic [6:0]                     out_key_number,
  output logic                           out_last,
  output logic [6:0]                     out_held_total,
  output logic                           out_rejected,
  output logic                           out_sustain_latched,
  output logic                           out_voices_started,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nht_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [nht_pkg::LIMIT_W-1:0] held_limit_r;
  logic                        reg_sel;
  nht_pkg::item_t              item;
  nht_pkg::result_t            res;
  nht_pkg::tbl_req_t           tbl_req;
  logic [nht_pkg::CNT_W-1:0]   tbl_rd_data;

  // Register decode
  assign reg_sel = (paddr[nht_pkg::CFG_ADDR_W-1:2] == nht_pkg::REG_HELD_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(held_limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_limit_r <= nht_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      held_limit_r <= pwdata[nht_pkg::LIMIT_W-1:0];
    end
  end

  // Input transaction fields
  assign item.operation   = in_operation;
  assign item.byte_count  = in_byte_count;
  assign item.status_byte = in_status_byte;
  assign item.data_one    = in_data_one;
  assign item.data_two    = in_data_two;

  nht_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .item        (item),
    .held_limit  (held_limit_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res),
    .tbl_req     (tbl_req),
    .tbl_rd_data (tbl_rd_data)
  );

  nht_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

  // Result transaction fields
  assign out_kind            = res.kind;
  assign out_midi_channel    = res.midi_channel;
  assign out_key_number      = res.key_number;
  assign out_last            = res.last;
  assign out_held_total      = res.held_total;
  assign out_rejected        = res.rejected;
  assign out_sustain_latched = res.sustain_latched;
  assign out_voices_started  = res.voices_started;

endmodule

// File: rtl/nht_checker.sv
// Port-level checks on the result channel, bound to the top level.
module nht_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [3:0] out_midi_channel,
  input logic [6:0] out_key_number,
  input logic       out_last,
  input logic [6:0] out_held_total,
  input logic       out_rejected
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_last) &&
      $stable(out_held_total) && $stable(out_key_number))
    else $error("stalled result changed");

  // Status results close their transaction and carry no note
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == nht_pkg::RES_STATUS) |->
      out_last && (out_midi_channel == 4'd0) && (out_key_number == 7'd0))
    else $error("malformed status result");

  // Generated note-offs are never marked rejected and need something held
  a_noteoff_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == nht_pkg::RES_NOTE_OFF) |->
      !out_rejected && (out_held_total != 7'd0))
    else $error("malformed note-off result");

  // Total never exceeds the admission ceiling
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_held_total <= nht_pkg::HELD_MAX_LIM))
    else $error("held total out of range");

endmodule

bind midi_held_note_tracker_unit nht_checker u_nht_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_midi_channel (out_midi_channel),
  .out_key_number   (out_key_number),
  .out_last         (out_last),
  .out_held_total   (out_held_total),
  .out_rejected     (out_rejected)
);

// File: sim/midi_held_note_tracker_unit_tb.sv
// Self-checking testbench for the MIDI held-note tracker: random and directed events, APB set-up.
module midi_held_note_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = '0;
  logic [1:0] in_byte_count = '0;
  logic [7:0] in_status_byte = '0;
  logic [7:0] in_data_one = '0;
  logic [7:0] in_data_two = '0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [3:0] out_midi_channel;
  logic [6:0] out_key_number;
  logic       out_last;
  logic [6:0] out_held_total;
  logic       out_rejected;
  logic       out_sustain_latched;
  logic       out_voices_started;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [nht_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  midi_held_note_tracker_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_byte_count       (in_byte_count),
    .in_status_byte      (in_status_byte),
    .in_data_one         (in_data_one),
    .in_data_two         (in_data_two),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_midi_channel    (out_midi_channel),
    .out_key_number      (out_key_number),
    .out_last            (out_last),
    .out_held_total      (out_held_total),
    .out_rejected        (out_rejected),
    .out_sustain_latched (out_sustain_latched),
    .out_voices_started  (out_voices_started),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  // Tracker state mirrored on the testbench side
  logic [6:0] note_counts [nht_pkg::KEY_SLOTS];
  int         held_sum;
  logic       pedal_seen;
  logic       voices_seen;
  logic [6:0] limit_reg;

  nht_pkg::item_t   pending_items [$];
  nht_pkg::result_t expected_results [$];
  nht_pkg::item_t   offer;

  int  queued_count = 0;
  int  accepted_count = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  cycle_limit = 4 * (nht_pkg::KEY_SLOTS + 200);
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;

  function automatic void clear_voices();
    for (int s = 0; s < nht_pkg::KEY_SLOTS; s++) note_counts[s] = '0;
    held_sum = 0;
    voices_seen = 1'b0;
  endfunction

  function automatic nht_pkg::result_t status_result(logic rej);
    nht_pkg::result_t r;
    r.kind            = nht_pkg::RES_STATUS;
    r.midi_channel    = '0;
    r.key_number      = '0;
    r.last            = 1'b1;
    r.held_total      = nht_pkg::CNT_W'(held_sum);
    r.rejected        = rej;
    r.sustain_latched = pedal_seen;
    r.voices_started  = voices_seen;
    return r;
  endfunction

  // Apply one transaction to the mirrored state and queue the results it should give
  function automatic void track_item(nht_pkg::item_t it);
    nht_pkg::result_t r;
    logic       rej;
    logic [3:0] msg;
    logic [10:0] slot;
    int         cap;
    int         n_out;
    int         emitted;
    rej = 1'b0;
    case (nht_pkg::op_t'(it.operation))
      nht_pkg::OP_CLEANUP: begin
        n_out = (held_sum > nht_pkg::HELD_MAX) ? nht_pkg::HELD_MAX : held_sum;
        emitted = 0;
        for (int s = 0; s < nht_pkg::KEY_SLOTS && emitted < n_out; s++) begin
          for (int c = 0; c < note_counts[s] && emitted < n_out; c++) begin
            r.kind            = nht_pkg::RES_NOTE_OFF;
            r.midi_channel    = 4'(s / 128);
            r.key_number      = 7'(s % 128);
            r.last            = (emitted + 1 == n_out);
            r.held_total      = nht_pkg::CNT_W'(held_sum);
            r.rejected        = 1'b0;
            r.sustain_latched = pedal_seen;
            r.voices_started  = voices_seen;
            expected_results.push_back(r);
            emitted++;
          end
        end
        if (n_out == 0) expected_results.push_back(status_result(1'b0));
      end
      nht_pkg::OP_VOICE_RESET: begin
        clear_voices();
        expected_results.push_back(status_result(1'b0));
      end
      nht_pkg::OP_FULL_RESET: begin
        clear_voices();
        pedal_seen = 1'b0;
        expected_results.push_back(status_result(1'b0));
      end
      default: begin
        if (it.byte_count == nht_pkg::FULL_EVENT_LEN) begin
          msg  = it.status_byte[7:4];
          slot = {it.status_byte[3:0], it.data_one[6:0]};
          cap  = (limit_reg > nht_pkg::HELD_MAX_LIM) ? nht_pkg::HELD_MAX : int'(limit_reg);
          if (msg == nht_pkg::MSG_NOTE_ON && it.data_two != 8'd0) begin
            if (held_sum + 1 > cap) begin
              rej = 1'b1;
            end else begin
              note_counts[slot] = note_counts[slot] + 7'd1;
              held_sum++;
              voices_seen = 1'b1;
            end
          end else if ((msg == nht_pkg::MSG_NOTE_OFF || msg == nht_pkg::MSG_NOTE_ON) &&
                       note_counts[slot] != '0) begin
            note_counts[slot] = note_counts[slot] - 7'd1;
            held_sum--;
          end else if (msg == nht_pkg::MSG_CONTROLLER &&
                       (it.data_one == nht_pkg::CC_SUSTAIN ||
                        it.data_one == nht_pkg::CC_SOSTENUTO) &&
                       it.data_two >= nht_pkg::PEDAL_DOWN_MIN) begin
            pedal_seen = 1'b1;
          end
        end
        expected_results.push_back(status_result(rej));
      end
    endcase
  endfunction

  function automatic nht_pkg::item_t midi_item(logic [7:0] sb, logic [7:0] d1, logic [7:0] d2);
    nht_pkg::item_t it;
    it.operation   = nht_pkg::OP_EVENT;
    it.byte_count  = nht_pkg::FULL_EVENT_LEN;
    it.status_byte = sb;
    it.data_one    = d1;
    it.data_two    = d2;
    return it;
  endfunction

  function automatic nht_pkg::item_t op_item(nht_pkg::op_t op);
    nht_pkg::item_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  // Mostly well-formed events on a small set of keys so note-offs find held notes
  function automatic nht_pkg::item_t random_event(output bit tracked);
    nht_pkg::item_t it;
    int         pick;
    logic [3:0] ch;
    logic [7:0] key;
    logic [7:0] cc;
    pick = $urandom_range(99);
    ch   = ($urandom_range(99) < 70) ? 4'($urandom_range(2)) : 4'($urandom_range(15));
    key  = ($urandom_range(99) < 75) ? 8'(60 + $urandom_range(7)) : 8'($urandom_range(255));
    cc   = ($urandom_range(1)) ? nht_pkg::CC_SUSTAIN : nht_pkg::CC_SOSTENUTO;
    if ($urandom_range(3) == 0) cc = 8'($urandom_range(255));
    tracked = 1'b1;
    if (pick < 44) begin
      it = midi_item({nht_pkg::MSG_NOTE_ON, ch}, key, 8'($urandom_range(1, 255)));
    end else if (pick < 54) begin
      it = midi_item({nht_pkg::MSG_NOTE_ON, ch}, key, 8'd0);
    end else if (pick < 76) begin
      it = midi_item({nht_pkg::MSG_NOTE_OFF, ch}, key, 8'($urandom_range(255)));
    end else if (pick < 85) begin
      it = midi_item({nht_pkg::MSG_CONTROLLER, ch}, cc, 8'($urandom_range(255)));
    end else if (pick < 89) begin
      it = op_item(nht_pkg::OP_CLEANUP);
    end else if (pick < 91) begin
      it = op_item(nht_pkg::OP_VOICE_RESET);
    end else if (pick < 92) begin
      it = op_item(nht_pkg::OP_FULL_RESET);
    end else begin
      // noise: short or arbitrary events
      tracked        = 1'b0;
      it.operation   = nht_pkg::OP_EVENT;
      it.byte_count  = 2'($urandom_range(3));
      it.status_byte = 8'($urandom_range(255));
      it.data_one    = 8'($urandom_range(255));
      it.data_two    = 8'($urandom_range(255));
    end
    return it;
  endfunction

  // Hand a transaction to the driver and extend the cycle budget to cover it
  task automatic queue_item(nht_pkg::item_t it);
    int cost;
    case (nht_pkg::op_t'(it.operation))
      nht_pkg::OP_CLEANUP:     cost = 2 * nht_pkg::KEY_SLOTS + nht_pkg::HELD_MAX * 40;
      nht_pkg::OP_VOICE_RESET: cost = nht_pkg::KEY_SLOTS + 100;
      nht_pkg::OP_FULL_RESET:  cost = nht_pkg::KEY_SLOTS + 100;
      default:                 cost = 60;
    endcase
    pending_items.push_back(it);
    queued_count++;
    cycle_limit += 4 * cost;
  endtask

  task automatic add_random(int n);
    nht_pkg::item_t it;
    bit    tracked;
    int    counted;
    counted = 0;
    while (counted < n) begin
      it = random_event(tracked);
      queue_item(it);
      if (tracked) counted++;
    end
  endtask

  task automatic await_drain();
    while (accepted_count != queued_count || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write of the held limit, then read it back
  task automatic program_limit(logic [6:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {nht_pkg::REG_HELD_LIMIT, 2'b00};
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_reg = value;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {25'd0, value}) begin
      $display("%0t: held_limit readback expected %0h got %0h", $time, value, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: offers the next pending transaction once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_item(offer);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
          offer = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= offer.operation;
          in_byte_count  <= offer.byte_count;
          in_status_byte <= offer.status_byte;
          in_data_one    <= offer.data_one;
          in_data_two    <= offer.data_two;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Monitor: checks each result transaction and drives the receiver's stall
  always @(posedge clk) begin
    nht_pkg::result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: expected no result, got kind %0d channel %0d key %0d total %0d",
                   $time, out_kind, out_midi_channel, out_key_number, out_held_total);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          report_field("kind", want.kind, out_kind);
          report_field("midi_channel", want.midi_channel, out_midi_channel);
          report_field("key_number", want.key_number, out_key_number);
          report_field("last", want.last, out_last);
          report_field("held_total", want.held_total, out_held_total);
          report_field("rejected", want.rejected, out_rejected);
          report_field("sustain_latched", want.sustain_latched, out_sustain_latched);
          report_field("voices_started", want.voices_started, out_voices_started);
        end
      end
      if (hold_served != hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    nht_pkg::item_t short_ev;
    clear_voices();
    pedal_seen = 1'b0;
    limit_reg  = nht_pkg::LIMIT_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every operation, short and odd events
    program_limit(7'd64);
    queue_item(op_item(nht_pkg::OP_CLEANUP));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd0}, 8'd0, 8'd127));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd15}, 8'd127, 8'd1));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd15}, 8'd127, 8'd255));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd15}, 8'd255, 8'd64));
    for (int b = 0; b < 3; b++) begin
      short_ev = midi_item({nht_pkg::MSG_NOTE_ON, 4'd5}, 8'd40, 8'd100);
      short_ev.byte_count = 2'(b);
      queue_item(short_ev);
    end
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd0}, 8'd0, 8'd0));
    queue_item(midi_item({nht_pkg::MSG_NOTE_OFF, 4'd3}, 8'd9, 8'd0));
    queue_item(midi_item({nht_pkg::MSG_NOTE_OFF, 4'd15}, 8'd127, 8'd64));
    queue_item(midi_item({nht_pkg::MSG_CONTROLLER, 4'd0}, nht_pkg::CC_SUSTAIN, 8'd63));
    queue_item(midi_item({nht_pkg::MSG_CONTROLLER, 4'd2}, 8'd65, 8'd127));
    queue_item(midi_item({nht_pkg::MSG_CONTROLLER, 4'd7}, nht_pkg::CC_SOSTENUTO,
                         nht_pkg::PEDAL_DOWN_MIN));
    queue_item(midi_item({nht_pkg::MSG_CONTROLLER, 4'd15}, nht_pkg::CC_SUSTAIN, 8'd255));
    queue_item(midi_item(8'he0, 8'd127, 8'd127));
    queue_item(midi_item(8'hf0, 8'd0, 8'd0));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd9}, 8'd60, 8'd90));
    queue_item(op_item(nht_pkg::OP_CLEANUP));
    queue_item(op_item(nht_pkg::OP_VOICE_RESET));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd1}, 8'd1, 8'd1));
    queue_item(op_item(nht_pkg::OP_FULL_RESET));
    await_drain();

    // Limit of one: second note-on refused until the first is released
    program_limit(7'd1);
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd3}, 8'd10, 8'd80));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd3}, 8'd11, 8'd80));
    queue_item(midi_item({nht_pkg::MSG_NOTE_OFF, 4'd3}, 8'd10, 8'd0));
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd3}, 8'd11, 8'd80));
    add_random(40);
    await_drain();

    // Limit of zero admits nothing
    program_limit(7'd0);
    queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'd0}, 8'd64, 8'd100));
    add_random(20);
    await_drain();

    // Limit above the maximum, no idling, receiver held off as the table begins to fill
    program_limit(7'd127);
    calm <= 1'b1;
    hold_requests <= hold_requests + 1;
    cycle_limit += 4 * (HOLD_CYCLES + 100);
    for (int i = 0; i < 66; i++) begin
      queue_item(midi_item({nht_pkg::MSG_NOTE_ON, 4'(i % 8)}, 8'((i * 7) % 40), 8'(1 + i)));
    end
    queue_item(op_item(nht_pkg::OP_CLEANUP));
    queue_item(op_item(nht_pkg::OP_CLEANUP));
    queue_item(op_item(nht_pkg::OP_VOICE_RESET));
    await_drain();
    calm <= 1'b0;

    program_limit(7'd20);
    add_random(100);
    await_drain();

    program_limit(7'd64);
    add_random(150);
    await_drain();

    program_limit(7'd37);
    add_random(50);
    await_drain();

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
